[rtl/core/hhcr_pkg.sv]
// hhcr_pkg: shared constants, register codes and hall successor tables
// for the hall hold current ramp; no dependencies
`timescale 1ns / 1ps

package hhcr_pkg;

  localparam int MAX_STEPS      = 25;
  localparam int HIST_DEPTH     = MAX_STEPS + 2;
  localparam int HIST_AW        = $clog2(HIST_DEPTH);
  localparam int COUNT_W        = 5;
  localparam int CALC_W         = COUNT_W + 1;
  localparam int STEP_FLOOR     = 4;
  localparam int REVERSAL_CAP   = 10;
  localparam int COOLDOWN_AFTER = 3;
  localparam int Q15_W          = 15;
  localparam int TICK_W         = 16;
  localparam int REV_W          = 4;
  localparam int HALL_W         = 3;
  localparam int PROD_W         = COUNT_W + Q15_W;
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 16;
  localparam logic [Q15_W-1:0] Q15_MAX = '1;

  typedef enum logic [CFG_AW-1:0] {
    REG_STEP_GAIN      = 3'd0,
    REG_TARGET_CEILING = 3'd1,
    REG_RISE_PERIOD    = 3'd2,
    REG_RISE_AMOUNT    = 3'd3,
    REG_FALL_PERIOD    = 3'd4,
    REG_FALL_AMOUNT    = 3'd5
  } cfg_reg_t;

  // forward successor, invalid codes map to 0
  function automatic logic [HALL_W-1:0] fwd_next(input logic [HALL_W-1:0] code);
    logic [HALL_W-1:0] r;
    unique case (code)
      3'd1:    r = 3'd3;
      3'd2:    r = 3'd6;
      3'd3:    r = 3'd2;
      3'd4:    r = 3'd5;
      3'd5:    r = 3'd1;
      3'd6:    r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // reverse successor, invalid codes map to 0
  function automatic logic [HALL_W-1:0] rev_next(input logic [HALL_W-1:0] code);
    logic [HALL_W-1:0] r;
    unique case (code)
      3'd1:    r = 3'd5;
      3'd2:    r = 3'd3;
      3'd3:    r = 3'd1;
      3'd4:    r = 3'd6;
      3'd5:    r = 3'd4;
      3'd6:    r = 3'd2;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/hhcr_if.sv]
// hhcr_if: valid/ready channels for control ticks and ramp results
// depends on hhcr_pkg
`timescale 1ns / 1ps

interface hhcr_tick_if;
  logic                          valid;
  logic                          ready;
  logic                          hold_active;
  logic [hhcr_pkg::HALL_W-1:0]   hall_now;
  logic [hhcr_pkg::HALL_W-1:0]   hall_at_lock;
  logic                          cooldown_active;

  modport source (output valid, hold_active, hall_now, hall_at_lock, cooldown_active,
                  input ready);
  modport sink   (input valid, hold_active, hall_now, hall_at_lock, cooldown_active,
                  output ready);
endinterface

interface hhcr_result_if;
  logic                          valid;
  logic                          ready;
  logic [hhcr_pkg::Q15_W-1:0]    current_limit;
  logic [hhcr_pkg::Q15_W-1:0]    current_target;
  logic [hhcr_pkg::COUNT_W-1:0]  steps_moved;
  logic                          moving_forward;
  logic [hhcr_pkg::REV_W-1:0]    reversal_count;
  logic                          start_cooldown;

  modport source (output valid, current_limit, current_target, steps_moved,
                  moving_forward, reversal_count, start_cooldown, input ready);
  modport sink   (input valid, current_limit, current_target, steps_moved,
                  moving_forward, reversal_count, start_cooldown, output ready);
endinterface

[rtl/core/hall_hold_current_ramp.sv]
// hall_hold_current_ramp: hall step tracking, reversal count and q15 current ramp
// depends on hhcr_pkg and the channels in hhcr_if
`timescale 1ns / 1ps

//  channel  dir  transfer when         payload
//  tick     in   valid & ready         hold_active, hall_now, hall_at_lock, cooldown_active
//  result   out  valid & ready         current_limit, current_target, steps_moved,
//                                      moving_forward, reversal_count, start_cooldown
//  cfg      in   cfg_write             cfg_index, cfg_data
//
// one tick per cycle while tick.ready is high: state and result register update on the tick transfer,
// and the result is registered and appears on the next cycle
// tick.ready is high whenever the result register is empty or being taken
// reset clears state, config (ceiling to full scale) and the result valid
// step history has no reset and holds nothing until written

module hall_hold_current_ramp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [hhcr_pkg::CFG_AW-1:0]   cfg_index,
  input  logic [hhcr_pkg::CFG_DW-1:0]   cfg_data,
  hhcr_tick_if.sink                     tick,
  hhcr_result_if.source                 result
);

  localparam int QW = hhcr_pkg::Q15_W;
  localparam int TW = hhcr_pkg::TICK_W;
  localparam int CW = hhcr_pkg::COUNT_W;
  localparam int XW = hhcr_pkg::CALC_W;
  localparam int HW = hhcr_pkg::HALL_W;
  localparam int RW = hhcr_pkg::REV_W;
  localparam int AW = hhcr_pkg::HIST_AW;

  // configuration
  logic [QW-1:0] step_gain, target_ceiling, rise_amount, fall_amount;
  logic [TW-1:0] rise_period, fall_period;

  // state
  logic [CW-1:0] step_count;
  logic          forward_dir;
  logic [HW-1:0] history [hhcr_pkg::HIST_DEPTH];
  logic [RW-1:0] reversals;
  logic          last_reversal_dir;
  logic [QW-1:0] limit_value;
  logic [TW-1:0] rise_ticks, fall_ticks;

  // result register
  logic          res_valid;
  logic [QW-1:0] res_limit, res_target;
  logic [CW-1:0] res_steps;
  logic          res_forward;
  logic [RW-1:0] res_reversals;
  logic          res_request;

  // next values
  logic [CW-1:0] step_count_next;
  logic          forward_dir_next;
  logic [RW-1:0] reversals_next;
  logic          last_reversal_dir_next;
  logic [QW-1:0] limit_value_next, target_next;
  logic [TW-1:0] rise_ticks_next, fall_ticks_next;
  logic          request_next;

  logic          hist_we;
  logic [AW-1:0] hist_waddr;
  logic [HW-1:0] prev_code, ahead, back;
  logic [XW-1:0] cnt_calc;
  logic [hhcr_pkg::PROD_W-1:0] prod;
  logic [QW:0]   rise_sum;
  logic          accept;

  assign tick.ready = !res_valid || result.ready;
  assign accept     = tick.valid && tick.ready;

  assign prev_code = history[AW'(step_count)];
  assign ahead     = forward_dir ? hhcr_pkg::fwd_next(prev_code)
                                 : hhcr_pkg::rev_next(prev_code);
  assign back      = forward_dir ? hhcr_pkg::rev_next(prev_code)
                                 : hhcr_pkg::fwd_next(prev_code);

  // hall tracking
  always_comb begin
    cnt_calc         = XW'(step_count);
    forward_dir_next = forward_dir;
    hist_we          = 1'b0;
    hist_waddr       = AW'(step_count);
    request_next     = 1'b0;
    if (tick.hold_active) begin
      if (step_count == '0) begin
        if (tick.hall_now != tick.hall_at_lock) begin
          cnt_calc   = XW'(1);
          hist_we    = 1'b1;
          hist_waddr = AW'(1);
          if (tick.hall_now == hhcr_pkg::fwd_next(tick.hall_at_lock)) begin
            forward_dir_next = 1'b1;
          end else if (tick.hall_now == hhcr_pkg::rev_next(tick.hall_at_lock)) begin
            forward_dir_next = 1'b0;
          end
        end
      end else begin
        if (tick.hall_now != prev_code) begin
          if (tick.hall_now == ahead) begin
            cnt_calc = XW'(step_count) + XW'(1);
          end else if (tick.hall_now == back) begin
            cnt_calc = XW'(step_count) - XW'(1);
          end
          hist_we    = 1'b1;
          hist_waddr = (cnt_calc < XW'(hhcr_pkg::HIST_DEPTH)) ? AW'(cnt_calc)
                                                             : AW'(hhcr_pkg::HIST_DEPTH - 1);
        end
        if (cnt_calc > XW'(hhcr_pkg::MAX_STEPS)) begin
          cnt_calc = XW'(hhcr_pkg::MAX_STEPS);
        end
      end
      request_next = !tick.cooldown_active && (reversals > RW'(hhcr_pkg::COOLDOWN_AFTER));
    end
    step_count_next = CW'(cnt_calc);
  end

  // reversals and target
  always_comb begin
    reversals_next         = reversals;
    last_reversal_dir_next = last_reversal_dir;
    target_next            = '0;
    prod = hhcr_pkg::PROD_W'(step_count_next - CW'(hhcr_pkg::STEP_FLOOR)) *
           hhcr_pkg::PROD_W'(step_gain);
    if (step_count_next >= CW'(hhcr_pkg::STEP_FLOOR)) begin
      if (reversals == '0) begin
        last_reversal_dir_next = forward_dir_next;
        reversals_next         = RW'(1);
      end else if (forward_dir_next != last_reversal_dir) begin
        if (reversals <= RW'(hhcr_pkg::REVERSAL_CAP)) begin
          reversals_next = reversals + RW'(1);
        end
        last_reversal_dir_next = forward_dir_next;
      end
      target_next = (prod > hhcr_pkg::PROD_W'(target_ceiling)) ? target_ceiling
                                                              : prod[QW-1:0];
    end
  end

  // limit ramp
  always_comb begin
    limit_value_next = limit_value;
    rise_ticks_next  = rise_ticks;
    fall_ticks_next  = fall_ticks;
    rise_sum         = {1'b0, limit_value} + {1'b0, rise_amount};
    if (target_next > limit_value) begin
      if (rise_ticks > rise_period) begin
        rise_ticks_next  = '0;
        limit_value_next = rise_sum[QW] ? hhcr_pkg::Q15_MAX : rise_sum[QW-1:0];
      end else begin
        rise_ticks_next = rise_ticks + TW'(1);
      end
    end else if (target_next < limit_value) begin
      if (fall_ticks > fall_period) begin
        fall_ticks_next  = '0;
        limit_value_next = (limit_value > fall_amount) ? limit_value - fall_amount : '0;
      end else begin
        fall_ticks_next = fall_ticks + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_gain      <= '0;
      target_ceiling <= hhcr_pkg::Q15_MAX;
      rise_period    <= '0;
      rise_amount    <= '0;
      fall_period    <= '0;
      fall_amount    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hhcr_pkg::REG_STEP_GAIN:      step_gain      <= cfg_data[QW-1:0];
        hhcr_pkg::REG_TARGET_CEILING: target_ceiling <= cfg_data[QW-1:0];
        hhcr_pkg::REG_RISE_PERIOD:    rise_period    <= cfg_data[TW-1:0];
        hhcr_pkg::REG_RISE_AMOUNT:    rise_amount    <= cfg_data[QW-1:0];
        hhcr_pkg::REG_FALL_PERIOD:    fall_period    <= cfg_data[TW-1:0];
        hhcr_pkg::REG_FALL_AMOUNT:    fall_amount    <= cfg_data[QW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count        <= '0;
      forward_dir       <= 1'b0;
      reversals         <= '0;
      last_reversal_dir <= 1'b0;
      limit_value       <= '0;
      rise_ticks        <= '0;
      fall_ticks        <= '0;
      res_valid         <= 1'b0;
    end else begin
      if (accept) begin
        step_count        <= step_count_next;
        forward_dir       <= forward_dir_next;
        reversals         <= reversals_next;
        last_reversal_dir <= last_reversal_dir_next;
        limit_value       <= limit_value_next;
        rise_ticks        <= rise_ticks_next;
        fall_ticks        <= fall_ticks_next;
        res_valid         <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_limit     <= limit_value_next;
      res_target    <= target_next;
      res_steps     <= step_count_next;
      res_forward   <= forward_dir_next;
      res_reversals <= reversals_next;
      res_request   <= request_next;
      if (hist_we) begin
        history[hist_waddr] <= tick.hall_now;
      end
    end
  end

  assign result.valid          = res_valid;
  assign result.current_limit  = res_limit;
  assign result.current_target = res_target;
  assign result.steps_moved    = res_steps;
  assign result.moving_forward = res_forward;
  assign result.reversal_count = res_reversals;
  assign result.start_cooldown = res_request;

  a_steps_bounded: assert property (@(posedge clk) disable iff (rst)
    step_count <= CW'(hhcr_pkg::MAX_STEPS))
    else $error("step count above clamp");

  a_reversals_bounded: assert property (@(posedge clk) disable iff (rst)
    reversals <= RW'(hhcr_pkg::REVERSAL_CAP + 1))
    else $error("reversal count above cap");

  a_request_needs_reversals: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_request |-> res_reversals > RW'(hhcr_pkg::COOLDOWN_AFTER))
    else $error("cooldown request without enough reversals");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> tick.ready)
    else $error("tick stalled with empty result register");

endmodule
